>>> rtl/core/spq_pkg.sv
// Package with operation codes, status codes and cell control types of the priority queue.
package spq_pkg;

   localparam int KIND_WIDTH   = 2;
   localparam int STATUS_WIDTH = 2;
   localparam int RSP_USER_WIDTH = STATUS_WIDTH + 1;

   localparam logic [KIND_WIDTH-1:0] KIND_ENQ = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_DEQ = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_CLR = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic enq;
      logic deq;
      logic clr;
   } cell_ctrl_type;

endpackage

>>> rtl/core/spq_cell.sv
// One compare-and-shift cell of the sorted priority queue chain.
module spq_cell #(
   parameter int PRIO_WIDTH = 4,
   parameter int TAG_WIDTH  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic [PRIO_WIDTH-1:0] new_prio,
   input  logic [TAG_WIDTH-1:0]  new_tag,
   input  logic                  left_valid,
   input  logic                  left_keep,
   input  logic [PRIO_WIDTH-1:0] left_prio,
   input  logic [TAG_WIDTH-1:0]  left_tag,
   input  logic                  right_valid,
   input  logic [PRIO_WIDTH-1:0] right_prio,
   input  logic [TAG_WIDTH-1:0]  right_tag,
   output logic                  valid,
   output logic                  keep,
   output logic [PRIO_WIDTH-1:0] prio,
   output logic [TAG_WIDTH-1:0]  tag
);
   import spq_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [PRIO_WIDTH-1:0] prio_ff;
   logic [PRIO_WIDTH-1:0] prio_in;
   logic [TAG_WIDTH-1:0]  tag_ff;
   logic [TAG_WIDTH-1:0]  tag_in;

   // An entry stays in place when it is ahead of the new one, ties included.
   assign keep = valid_ff && (prio_ff <= new_prio);

   always_comb begin
      valid_in = valid_ff;
      prio_in  = prio_ff;
      tag_in   = tag_ff;
      if (ctrl.clr) begin
         valid_in = 1'b0;
      end else if (ctrl.enq) begin
         valid_in = valid_ff || left_valid;
         if (!keep) begin
            if (left_keep) begin
               prio_in = new_prio;
               tag_in  = new_tag;
            end else begin
               prio_in = left_prio;
               tag_in  = left_tag;
            end
         end
      end else if (ctrl.deq) begin
         valid_in = right_valid;
         prio_in  = right_prio;
         tag_in   = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      tag_ff  <= tag_in;
   end

   assign valid = valid_ff;
   assign prio  = prio_ff;
   assign tag   = tag_ff;

endmodule

>>> rtl/core/stable_priority_queue_core.sv
// Top level of the stable minimum priority queue built from a chain of cells.
// A result is registered and presented in the cycle after its transaction is accepted.
// Throughput: one operation per cycle unless a result waits; every cell compares and shifts in the same cycle.
// Reset: synchronous and active high; it empties the queue and the result register.
// Stored priorities and tags are not reset.
module stable_priority_queue_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int PRIO_WIDTH  = 4,
   parameter int TAG_WIDTH   = 16,
   localparam int OCC_WIDTH      = $clog2(QUEUE_DEPTH + 1),
   localparam int REQ_DATA_WIDTH = ((PRIO_WIDTH + TAG_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_WIDTH = ((PRIO_WIDTH + TAG_WIDTH + OCC_WIDTH + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: prio_in, tag_in, zero fill.
   input  logic [REQ_DATA_WIDTH-1:0]           req_tdata,
   // Fields from bit 0: kind.
   input  logic [spq_pkg::KIND_WIDTH-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: prio_out, tag_out, occupancy, zero fill.
   output logic [RSP_DATA_WIDTH-1:0]           rsp_tdata,
   // Fields from bit 0: status, out_valid.
   output logic [spq_pkg::RSP_USER_WIDTH-1:0]  rsp_tuser
);
   import spq_pkg::*;

   logic                    fire;
   logic [KIND_WIDTH-1:0]   kind;
   logic [PRIO_WIDTH-1:0]   prio;
   logic [TAG_WIDTH-1:0]    tag;
   logic                    full;
   logic                    empty;
   cell_ctrl_type           ctrl;

   logic [OCC_WIDTH-1:0]    count_ff;
   logic [OCC_WIDTH-1:0]    count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [STATUS_WIDTH-1:0] status_ff;
   logic [STATUS_WIDTH-1:0] status_in;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic [PRIO_WIDTH-1:0]   prio_out_ff;
   logic [PRIO_WIDTH-1:0]   prio_out_in;
   logic [TAG_WIDTH-1:0]    tag_out_ff;
   logic [TAG_WIDTH-1:0]    tag_out_in;
   logic [OCC_WIDTH-1:0]    occ_ff;

   logic [QUEUE_DEPTH-1:0]  cell_valid;
   logic [QUEUE_DEPTH-1:0]  cell_keep;
   logic [PRIO_WIDTH-1:0]   cell_prio [QUEUE_DEPTH];
   logic [TAG_WIDTH-1:0]    cell_tag  [QUEUE_DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;
   assign kind       = req_tuser;
   assign prio       = req_tdata[PRIO_WIDTH-1:0];
   assign tag        = req_tdata[PRIO_WIDTH+TAG_WIDTH-1:PRIO_WIDTH];
   assign full       = (count_ff == OCC_WIDTH'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);

   assign ctrl.enq = fire && (kind == KIND_ENQ) && !full;
   assign ctrl.deq = fire && (kind == KIND_DEQ) && !empty;
   assign ctrl.clr = fire && (kind == KIND_CLR);

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                  left_valid;
      logic                  left_keep;
      logic [PRIO_WIDTH-1:0] left_prio;
      logic [TAG_WIDTH-1:0]  left_tag;
      logic                  right_valid;
      logic [PRIO_WIDTH-1:0] right_prio;
      logic [TAG_WIDTH-1:0]  right_tag;

      if (i == 0) begin : g_head
         assign left_valid = 1'b1;
         assign left_keep  = 1'b1;
         assign left_prio  = prio;
         assign left_tag   = tag;
      end else begin : g_body
         assign left_valid = cell_valid[i-1];
         assign left_keep  = cell_keep[i-1];
         assign left_prio  = cell_prio[i-1];
         assign left_tag   = cell_tag[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_valid = 1'b0;
         assign right_prio  = '0;
         assign right_tag   = '0;
      end else begin : g_inner
         assign right_valid = cell_valid[i+1];
         assign right_prio  = cell_prio[i+1];
         assign right_tag   = cell_tag[i+1];
      end

      spq_cell #(
         .PRIO_WIDTH(PRIO_WIDTH),
         .TAG_WIDTH (TAG_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_prio   (prio),
         .new_tag    (tag),
         .left_valid (left_valid),
         .left_keep  (left_keep),
         .left_prio  (left_prio),
         .left_tag   (left_tag),
         .right_valid(right_valid),
         .right_prio (right_prio),
         .right_tag  (right_tag),
         .valid      (cell_valid[i]),
         .keep       (cell_keep[i]),
         .prio       (cell_prio[i]),
         .tag        (cell_tag[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      status_in    = STATUS_OK;
      out_valid_in = 1'b0;
      prio_out_in  = '0;
      tag_out_in   = '0;
      unique case (kind)
         KIND_ENQ: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + OCC_WIDTH'(1);
            end
         end
         KIND_DEQ: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in     = count_ff - OCC_WIDTH'(1);
               out_valid_in = 1'b1;
               prio_out_in  = cell_prio[0];
               tag_out_in   = cell_tag[0];
            end
         end
         KIND_CLR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff    <= status_in;
         out_valid_ff <= out_valid_in;
         prio_out_ff  <= prio_out_in;
         tag_out_ff   <= tag_out_in;
         occ_ff       <= count_in;
      end
   end

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[PRIO_WIDTH-1:0] = prio_out_ff;
      rsp_tdata[PRIO_WIDTH+TAG_WIDTH-1:PRIO_WIDTH] = tag_out_ff;
      rsp_tdata[PRIO_WIDTH+TAG_WIDTH+OCC_WIDTH-1:PRIO_WIDTH+TAG_WIDTH] = occ_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {out_valid_ff, status_ff};

`ifndef SYNTH
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == 32'(count_ff))
      else $error("Entry count disagrees with the occupied cells.");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= OCC_WIDTH'(QUEUE_DEPTH))
      else $error("Entry count exceeds the queue depth.");

   a_head_ordered: assert property (@(posedge clock) disable iff (reset)
      cell_valid[1] |-> (cell_prio[0] <= cell_prio[1]))
      else $error("Head entries are out of priority order.");

   a_deq_returns_entry: assert property (@(posedge clock) disable iff (reset)
      (fire && (kind == KIND_DEQ) && !empty) |=> (rsp_tvalid && out_valid_ff))
      else $error("Dequeue of a held entry returned no entry.");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the stable minimum priority queue core.
module tb_top;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH    = 16;
   localparam int PRIO_WIDTH     = 4;
   localparam int TAG_WIDTH      = 16;
   localparam int OCC_WIDTH      = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_DATA_WIDTH = ((PRIO_WIDTH + TAG_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = ((PRIO_WIDTH + TAG_WIDTH + OCC_WIDTH + 7) / 8) * 8;
   localparam logic [KIND_WIDTH-1:0] KIND_NOP = 2'd3;
   localparam int RANDOM_OPS     = 1950;
   localparam int CYCLE_LIMIT    = 2000000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [PRIO_WIDTH-1:0] prio;
      logic [TAG_WIDTH-1:0]  tag;
   } entry_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0] kind;
      entry_type             entry;
   } request_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic                    out_valid;
      entry_type               entry;
      logic [OCC_WIDTH-1:0]    occupancy;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic [KIND_WIDTH-1:0] req_tuser = KIND_NOP;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [RSP_USER_WIDTH-1:0] rsp_tuser;

   entry_type   held_entries[$];
   request_type pending_requests[$];
   result_type  expected_results[$];
   request_type active_request;

   int total_requests = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int enq_count = 0;
   int full_count = 0;
   int deq_count = 0;
   int empty_count = 0;
   int clear_count = 0;
   int nop_count = 0;
   int peak_occupancy = 0;
   int source_gap = 0;
   int sink_hold = 0;
   bit source_calm = 1'b0;
   bit sink_calm = 1'b0;

   stable_priority_queue_core #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .PRIO_WIDTH (PRIO_WIDTH),
      .TAG_WIDTH  (TAG_WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         return $urandom_range(1, 3);
      end else if (pick < 95) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic result_type next_queue_result(request_type req);
      result_type res;
      int pos;
      res = '0;
      case (req.kind)
         KIND_ENQ: begin
            if (held_entries.size() >= QUEUE_DEPTH) begin
               res.status = STATUS_FULL;
               full_count++;
            end else begin
               // A new entry goes behind every held entry of lower or equal priority.
               pos = 0;
               while (pos < held_entries.size() && held_entries[pos].prio <= req.entry.prio)
                  pos++;
               held_entries.insert(pos, req.entry);
               enq_count++;
            end
         end
         KIND_DEQ: begin
            if (held_entries.size() == 0) begin
               res.status = STATUS_EMPTY;
               empty_count++;
            end else begin
               res.out_valid = 1'b1;
               res.entry = held_entries.pop_front();
               deq_count++;
            end
         end
         KIND_CLR: begin
            held_entries.delete();
            clear_count++;
         end
         default: begin
            nop_count++;
         end
      endcase
      res.occupancy = OCC_WIDTH'(held_entries.size());
      if (held_entries.size() > peak_occupancy)
         peak_occupancy = held_entries.size();
      return res;
   endfunction

   task automatic add_request(logic [KIND_WIDTH-1:0] kind, logic [PRIO_WIDTH-1:0] prio,
                              logic [TAG_WIDTH-1:0] tag);
      request_type req;
      req.kind = kind;
      req.entry.prio = prio;
      req.entry.tag = tag;
      pending_requests.push_back(req);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            expected_results.push_back(next_queue_result(active_request));
            accepted_count++;
         end
         if (source_gap > 0) begin
            source_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            active_request = pending_requests.pop_front();
            req_tuser <= active_request.kind;
            req_tdata <= {active_request.entry.tag, active_request.entry.prio};
            req_tvalid <= 1'b1;
            if (!source_calm && $urandom_range(0, 99) < 30)
               source_gap = idle_length();
            if ($urandom_range(0, 99) == 0)
               source_calm = !source_calm;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (sink_hold > 0) begin
         sink_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!sink_calm && $urandom_range(0, 99) < 20)
            sink_hold = idle_length();
         if ($urandom_range(0, 299) == 0)
            sink_calm = !sink_calm;
      end
   end

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.status = rsp_tuser[STATUS_WIDTH-1:0];
         seen.out_valid = rsp_tuser[STATUS_WIDTH];
         seen.entry.prio = rsp_tdata[PRIO_WIDTH-1:0];
         seen.entry.tag = rsp_tdata[PRIO_WIDTH +: TAG_WIDTH];
         seen.occupancy = rsp_tdata[PRIO_WIDTH + TAG_WIDTH +: OCC_WIDTH];
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display({"Unexpected result transaction: ",
                         "status %0d valid %0d prio %0d tag %h occ %0d"},
                        seen.status, seen.out_valid, seen.entry.prio, seen.entry.tag,
                        seen.occupancy);
         end else begin
            want = expected_results.pop_front();
            if (seen.status !== want.status || seen.out_valid !== want.out_valid ||
                seen.entry.prio !== want.entry.prio || seen.entry.tag !== want.entry.tag ||
                seen.occupancy !== want.occupancy) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("Mismatch: expected status %0d valid %0d prio %0d tag %h occ %0d",
                           want.status, want.out_valid, want.entry.prio, want.entry.tag,
                           want.occupancy);
                  $display("          actual   status %0d valid %0d prio %0d tag %h occ %0d",
                           seen.status, seen.out_valid, seen.entry.prio, seen.entry.tag,
                           seen.occupancy);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
                  expected_results.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      int random_count;
      int seg_len;
      int enq_share;
      int prio_lo;
      int prio_hi;
      int pick;
      logic [KIND_WIDTH-1:0] kind;
      logic [TAG_WIDTH-1:0] tag;

      // Directed opening: empty queue, extremes, ties at the low end and in the middle, clear and the unused kind.
      add_request(KIND_DEQ, 4'd0, 16'h0000);
      add_request(KIND_ENQ, 4'd15, 16'hFFFF);
      add_request(KIND_ENQ, 4'd0, 16'h0000);
      add_request(KIND_ENQ, 4'd7, 16'hA5A5);
      add_request(KIND_ENQ, 4'd7, 16'h5A5A);
      add_request(KIND_ENQ, 4'd0, 16'h1234);
      repeat (6) add_request(KIND_DEQ, 4'd9, 16'hFFFF);
      add_request(KIND_NOP, 4'd15, 16'hFFFF);
      add_request(KIND_ENQ, 4'd3, 16'h00FF);
      add_request(KIND_ENQ, 4'd12, 16'hFF00);
      add_request(KIND_NOP, 4'd5, 16'h0F0F);
      add_request(KIND_CLR, 4'd15, 16'hFFFF);
      add_request(KIND_DEQ, 4'd0, 16'h0000);
      add_request(KIND_CLR, 4'd0, 16'h0000);

      // Random segments lean toward filling, draining or mixing, often with a narrow
      // priority band so that ties are common.
      random_count = 0;
      while (random_count < RANDOM_OPS) begin
         seg_len = $urandom_range(20, 60);
         case ($urandom_range(0, 2))
            0: enq_share = 85;
            1: enq_share = 15;
            default: enq_share = 50;
         endcase
         if ($urandom_range(0, 99) < 40) begin
            prio_lo = $urandom_range(0, 15);
            prio_hi = prio_lo + $urandom_range(0, 2);
            if (prio_hi > 15)
               prio_hi = 15;
         end else begin
            prio_lo = 0;
            prio_hi = 15;
         end
         repeat (seg_len) begin
            pick = $urandom_range(0, 99);
            tag = TAG_WIDTH'($urandom);
            if ($urandom_range(0, 19) == 0)
               tag = $urandom_range(0, 1) ? '1 : '0;
            if (pick < 1) begin
               kind = KIND_NOP;
            end else if (pick < 3) begin
               kind = KIND_CLR;
            end else if ($urandom_range(0, 99) < enq_share) begin
               kind = KIND_ENQ;
            end else begin
               kind = KIND_DEQ;
            end
            add_request(kind, PRIO_WIDTH'($urandom_range(prio_lo, prio_hi)), tag);
            if (kind != KIND_NOP)
               random_count++;
         end
      end
      total_requests = pending_requests.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_requests || expected_results.size() > 0)
         @(negedge clock);
      repeat (10) @(negedge clock);

      $display("Run covered %0d transactions: %0d enqueued, %0d dropped on full, %0d dequeued,",
               accepted_count, enq_count, full_count, deq_count);
      $display({"%0d dequeues on empty, %0d clears, %0d unused kinds, ",
                "peak occupancy %0d, %0d errors."},
               empty_count, clear_count, nop_count, peak_occupancy, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
